FILE: rtl/ppnq_pkg.sv
// shared types and codes for the paced priority notice queue
`default_nettype none

package ppnq_pkg;

    typedef enum logic [1:0] {
        FUNC_RECEIVE = 2'd0,
        FUNC_DISMISS = 2'd1,
        FUNC_TICK    = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        EV_ACCEPTED  = 3'd0,
        EV_PRESENTED = 3'd1,
        EV_POPPED    = 3'd2,
        EV_FULL      = 3'd3,
        EV_BAD_PRI   = 3'd4
    } t_event;

    localparam logic [1:0]  PRI_STANDARD = 2'd0;
    localparam logic [1:0]  PRI_HIGH     = 2'd1;
    localparam logic [15:0] GAP_RESET    = 16'd2000;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] params;
        logic [7:0]  tag;
        logic        dismissed;
        logic        shown;
    } t_entry;

    typedef struct packed {
        logic add_head;
        logic add_tail;
        logic pop;
        logic dismiss;
        logic show;
    } t_ring_op;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] id;
        logic [31:0] params;
        logic [7:0]  tag;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ppnq_ring.sv
// double-ended notice store as a row of shifting cells, head always in cell 0
`default_nettype none

module ppnq_ring #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire ppnq_pkg::t_ring_op               i_op,
    input  wire ppnq_pkg::t_entry                 i_new_entry,
    output ppnq_pkg::t_entry                      o_head,
    output ppnq_pkg::t_entry                      o_second,
    output logic [$clog2(QUEUE_DEPTH + 1) - 1:0]  o_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ppnq_pkg::t_entry r_slot [QUEUE_DEPTH];
    ppnq_pkg::t_entry n_slot [QUEUE_DEPTH];
    ppnq_pkg::t_entry w_head_marked;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slot[i] = r_slot[i];
            if (i_op.add_head) begin
                if (i == 0) begin
                    n_slot[i] = i_new_entry;
                end else begin
                    n_slot[i] = r_slot[i-1];
                end
            end else if (i_op.add_tail && (r_count == CW'(i))) begin
                n_slot[i] = i_new_entry;
            end else if (i_op.pop) begin
                if (i == QUEUE_DEPTH - 1) begin
                    n_slot[i] = r_slot[i];
                end else begin
                    n_slot[i] = r_slot[i+1];
                end
            end
        end
        // marks land on the head after any shift
        w_head_marked = n_slot[0];
        if (i_op.dismiss) begin
            w_head_marked.dismissed = 1'b1;
        end
        if (i_op.show) begin
            w_head_marked.shown = 1'b1;
        end
        n_slot[0] = w_head_marked;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_op.add_head || i_op.add_tail) begin
            n_count = r_count + CW'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head   = r_slot[0];
    assign o_second = r_slot[1];
    assign o_count  = r_count;

endmodule

`default_nettype wire

FILE: rtl/ppnq_resq.sv
// result register with one pending slot for the second result of a tick
`default_nettype none

module ppnq_resq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_first_vld,
    input  wire ppnq_pkg::t_result i_first,
    input  wire logic              i_second_vld,
    input  wire ppnq_pkg::t_result i_second,
    output logic                   o_pending,
    output logic                   o_vld,
    output ppnq_pkg::t_result      o_result
);

    ppnq_pkg::t_result r_out;
    ppnq_pkg::t_result r_pend;
    logic              r_out_vld;
    logic              r_pend_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (r_pend_vld) begin
            r_out_vld  <= 1'b1;
            r_pend_vld <= 1'b0;
        end else begin
            r_out_vld  <= i_first_vld;
            r_pend_vld <= i_second_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_vld) begin
            r_out <= r_pend;
        end else begin
            r_out  <= i_first;
            r_pend <= i_second;
        end
    end

    assign o_pending = r_pend_vld;
    assign o_vld     = r_out_vld;
    assign o_result  = r_out;

endmodule

`default_nettype wire

FILE: rtl/paced_priority_notice_queue.sv
// top level: item decode, tag and gap timer, notice ring and result stage
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------------
//  item in   | i_func i_note_id i_note_params i_priority_req  | start high, busy low
//            | i_dismiss_tag i_delta_ms                       |
//  result    | o_event_res o_out_id o_out_params o_out_tag    | o_strobe, one cycle each
//            | o_last                                         |
//  config    | i_cfg_wdata (min gap, ms)                      | i_cfg_we
//
// an item is decoded and the ring updated in the cycle it is accepted; its first
// result shows on the next cycle. a tick that pops and then presents has two results:
// busy is high for one cycle while the second leaves the result stage, and no new item
// is taken then; other items let the next in at once. reset is synchronous, active
// low, empties the queue and loads the gap with 2000 ms. the receiver cannot stall.
`default_nettype none

module paced_priority_notice_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_note_id,
    input  wire logic [31:0] i_note_params,
    input  wire logic [1:0]  i_priority_req,
    input  wire logic [7:0]  i_dismiss_tag,
    input  wire logic [15:0] i_delta_ms,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_strobe,
    output logic [2:0]       o_event_res,
    output logic [31:0]      o_out_id,
    output logic [31:0]      o_out_params,
    output logic [7:0]       o_out_tag,
    output logic             o_last
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0] r_min_gap;
    logic [15:0] r_elapsed;
    logic [15:0] n_elapsed;
    logic [7:0]  r_next_tag;
    logic [7:0]  n_next_tag;

    ppnq_pkg::t_ring_op w_op;
    ppnq_pkg::t_entry   w_new_entry;
    ppnq_pkg::t_entry   w_head;
    ppnq_pkg::t_entry   w_second;
    ppnq_pkg::t_entry   w_after_head;
    logic [CW-1:0]      w_count;
    logic [CW-1:0]      w_count_after;

    ppnq_pkg::t_result  w_first;
    ppnq_pkg::t_result  w_second_res;
    ppnq_pkg::t_result  w_out;
    logic               w_first_vld;
    logic               w_second_vld;
    logic               w_pending;

    logic               w_accept;
    logic               w_has_entry;
    logic [16:0]        w_sum;
    logic [15:0]        w_sat;
    logic               w_fire;
    logic               w_pop;
    logic               w_present;

    assign w_accept    = start && !w_pending;
    assign w_has_entry = (w_count != '0);

    // saturating time sum and gap check for ticks
    assign w_sum   = {1'b0, r_elapsed} + {1'b0, i_delta_ms};
    assign w_sat   = w_sum[16] ? ppnq_pkg::ELAPSED_MAX : w_sum[15:0];
    assign w_fire  = w_has_entry && (w_sat >= r_min_gap);
    assign w_pop   = w_fire && w_head.dismissed;
    assign w_count_after = w_count - CW'(w_pop);
    assign w_after_head  = w_pop ? w_second : w_head;
    assign w_present     = w_fire && (w_count_after != '0) && !w_after_head.shown;

    assign w_new_entry = '{id: i_note_id, params: i_note_params, tag: r_next_tag,
                           dismissed: 1'b0, shown: 1'b0};

    always_comb begin
        w_op         = '0;
        n_elapsed    = r_elapsed;
        n_next_tag   = r_next_tag;
        w_first_vld  = 1'b0;
        w_second_vld = 1'b0;
        w_first      = '{event_res: ppnq_pkg::EV_ACCEPTED, id: i_note_id,
                         params: i_note_params, tag: 8'd0, last: 1'b1};
        w_second_res = '{event_res: ppnq_pkg::EV_PRESENTED, id: w_after_head.id,
                         params: w_after_head.params, tag: w_after_head.tag, last: 1'b1};
        if (w_accept) begin
            case (ppnq_pkg::t_func'(i_func))
                ppnq_pkg::FUNC_RECEIVE: begin
                    w_first_vld = 1'b1;
                    if (i_priority_req != ppnq_pkg::PRI_STANDARD &&
                        i_priority_req != ppnq_pkg::PRI_HIGH) begin
                        w_first.event_res = ppnq_pkg::EV_BAD_PRI;
                    end else if (w_count == CW'(QUEUE_DEPTH)) begin
                        w_first.event_res = ppnq_pkg::EV_FULL;
                    end else begin
                        w_first.tag     = r_next_tag;
                        n_next_tag      = r_next_tag + 8'd1;
                        w_op.add_head   = (i_priority_req == ppnq_pkg::PRI_HIGH);
                        w_op.add_tail   = (i_priority_req == ppnq_pkg::PRI_STANDARD);
                    end
                end
                ppnq_pkg::FUNC_DISMISS: begin
                    w_op.dismiss = w_has_entry && (w_head.tag == i_dismiss_tag);
                end
                ppnq_pkg::FUNC_TICK: begin
                    n_elapsed = w_present ? 16'd0 : w_sat;
                    w_op.pop  = w_pop;
                    w_op.show = w_present;
                    if (w_pop) begin
                        w_first_vld  = 1'b1;
                        w_first      = '{event_res: ppnq_pkg::EV_POPPED, id: w_head.id,
                                         params: w_head.params, tag: w_head.tag,
                                         last: !w_present};
                        w_second_vld = w_present;
                    end else if (w_present) begin
                        w_first_vld = 1'b1;
                        w_first     = w_second_res;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap  <= ppnq_pkg::GAP_RESET;
            r_elapsed  <= '0;
            r_next_tag <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_gap <= i_cfg_wdata;
            end
            r_elapsed  <= n_elapsed;
            r_next_tag <= n_next_tag;
        end
    end

    ppnq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_new_entry (w_new_entry),
        .o_head      (w_head),
        .o_second    (w_second),
        .o_count     (w_count)
    );

    ppnq_resq u_resq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_first_vld  (w_first_vld),
        .i_first      (w_first),
        .i_second_vld (w_second_vld),
        .i_second     (w_second_res),
        .o_pending    (w_pending),
        .o_vld        (o_strobe),
        .o_result     (w_out)
    );

    assign busy         = w_pending;
    assign o_event_res  = w_out.event_res;
    assign o_out_id     = w_out.id;
    assign o_out_params = w_out.params;
    assign o_out_tag    = w_out.tag;
    assign o_last       = w_out.last;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the paced priority notice queue
`default_nettype none

module tb;

    localparam int RING_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 420;
    localparam int PHASE_ITEMS = 90;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] PRI_INVALID_A = 2'd2;
    localparam logic [1:0] PRI_INVALID_B = 2'd3;

    // queue predictor plus the store of results still owed by the block
    class notice_scoreboard;
        ppnq_pkg::t_result owed_events[$];
        ppnq_pkg::t_result staged[2];
        logic [31:0] ring_id[RING_DEPTH];
        logic [31:0] ring_params[RING_DEPTH];
        logic [7:0]  ring_tag[RING_DEPTH];
        bit          ring_dismissed[RING_DEPTH];
        bit          ring_shown[RING_DEPTH];
        int          head;
        int          count;
        int          elapsed;
        int          gap;
        logic [7:0]  next_tag;
        int          errors;

        function new();
            head = 0;
            count = 0;
            elapsed = 0;
            gap = ppnq_pkg::GAP_RESET;
            next_tag = 8'd0;
            errors = 0;
            foreach (ring_id[i]) begin
                ring_id[i] = '0;
                ring_params[i] = '0;
                ring_tag[i] = '0;
                ring_dismissed[i] = 1'b0;
                ring_shown[i] = 1'b0;
            end
        endfunction

        function void set_gap(logic [15:0] value);
            gap = value;
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        function logic [7:0] head_tag();
            return ring_tag[head];
        endfunction

        function void note_item(logic [1:0] func, logic [31:0] id, logic [31:0] params,
                                logic [1:0] pri, logic [7:0] dtag, logic [15:0] delta);
            int n;
            int pos;
            ppnq_pkg::t_result r;
            n = 0;
            case (func)
                ppnq_pkg::FUNC_RECEIVE: begin
                    if (pri != ppnq_pkg::PRI_STANDARD && pri != ppnq_pkg::PRI_HIGH) begin
                        staged[n] = '{ppnq_pkg::EV_BAD_PRI, id, params, 8'd0, 1'b0};
                        n = n + 1;
                    end else if (count >= RING_DEPTH) begin
                        staged[n] = '{ppnq_pkg::EV_FULL, id, params, 8'd0, 1'b0};
                        n = n + 1;
                    end else begin
                        if (pri == ppnq_pkg::PRI_HIGH) begin
                            head = (head + RING_DEPTH - 1) % RING_DEPTH;
                            pos = head;
                        end else begin
                            pos = (head + count) % RING_DEPTH;
                        end
                        ring_id[pos] = id;
                        ring_params[pos] = params;
                        ring_tag[pos] = next_tag;
                        ring_dismissed[pos] = 1'b0;
                        ring_shown[pos] = 1'b0;
                        count = count + 1;
                        staged[n] = '{ppnq_pkg::EV_ACCEPTED, id, params, next_tag, 1'b0};
                        n = n + 1;
                        next_tag = next_tag + 8'd1;
                    end
                end
                ppnq_pkg::FUNC_DISMISS: begin
                    if (count > 0 && ring_tag[head] == dtag)
                        ring_dismissed[head] = 1'b1;
                end
                ppnq_pkg::FUNC_TICK: begin
                    elapsed = elapsed + delta;
                    if (elapsed > ppnq_pkg::ELAPSED_MAX)
                        elapsed = ppnq_pkg::ELAPSED_MAX;
                    if (count > 0 && elapsed >= gap) begin
                        if (ring_dismissed[head]) begin
                            staged[n] = '{ppnq_pkg::EV_POPPED, ring_id[head],
                                          ring_params[head], ring_tag[head], 1'b0};
                            n = n + 1;
                            head = (head + 1) % RING_DEPTH;
                            count = count - 1;
                        end
                        if (count > 0 && !ring_shown[head]) begin
                            staged[n] = '{ppnq_pkg::EV_PRESENTED, ring_id[head],
                                          ring_params[head], ring_tag[head], 1'b0};
                            n = n + 1;
                            ring_shown[head] = 1'b1;
                            elapsed = 0;
                        end
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < n; i++) begin
                r = staged[i];
                r.last = (i == n - 1);
                owed_events = {owed_events, r};
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors = errors + 1;
        endfunction

        function void check_result(ppnq_pkg::t_result got);
            ppnq_pkg::t_result want;
            if (owed_events.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual event %0d id %h",
                         $time, got.event_res, got.id);
                errors = errors + 1;
                return;
            end
            want = owed_events[0];
            owed_events.delete(0);
            if (got.event_res !== want.event_res)
                report("event_res", 32'(want.event_res), 32'(got.event_res));
            if (got.id !== want.id)
                report("out_id", want.id, got.id);
            if (got.params !== want.params)
                report("out_params", want.params, got.params);
            if (got.tag !== want.tag)
                report("out_tag", 32'(want.tag), 32'(got.tag));
            if (got.last !== want.last)
                report("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = ppnq_pkg::FUNC_RECEIVE;
    logic [31:0] i_note_id = '0;
    logic [31:0] i_note_params = '0;
    logic [1:0]  i_priority_req = ppnq_pkg::PRI_STANDARD;
    logic [7:0]  i_dismiss_tag = '0;
    logic [15:0] i_delta_ms = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_strobe;
    logic [2:0]  o_event_res;
    logic [31:0] o_out_id;
    logic [31:0] o_out_params;
    logic [7:0]  o_out_tag;
    logic        o_last;

    notice_scoreboard  sb;
    ppnq_pkg::t_result seen;
    int                quiet_cycles = 0;
    int                random_items = 0;
    int                phase = 0;
    int                burst_left = 0;

    paced_priority_notice_queue #(
        .QUEUE_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_note_id      (i_note_id),
        .i_note_params  (i_note_params),
        .i_priority_req (i_priority_req),
        .i_dismiss_tag  (i_dismiss_tag),
        .i_delta_ms     (i_delta_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_event_res    (o_event_res),
        .o_out_id       (o_out_id),
        .o_out_params   (o_out_params),
        .o_out_tag      (o_out_tag),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                seen.event_res = ppnq_pkg::t_event'(o_event_res);
                seen.id = o_out_id;
                seen.params = o_out_params;
                seen.tag = o_out_tag;
                seen.last = o_last;
                sb.check_result(seen);
            end
            if ((start && !busy) || o_strobe)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("paced_priority_notice_queue regression: fail");
                $finish;
            end
        end
    end

    // holds the transaction until the block takes it, then updates the predictor
    task automatic send_item(input logic [1:0] func, input logic [31:0] id,
                             input logic [31:0] params, input logic [1:0] pri,
                             input logic [7:0] dtag, input logic [15:0] delta);
        start <= 1'b1;
        i_func <= func;
        i_note_id <= id;
        i_note_params <= params;
        i_priority_req <= pri;
        i_dismiss_tag <= dtag;
        i_delta_ms <= delta;
        do @(posedge i_clk); while (busy);
        sb.note_item(func, id, params, pri, dtag, delta);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending until every owed result is back, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_gap(value);
    endtask

    task automatic run_directed();
        // tick and dismiss on an empty queue, bad priorities, then one receive of each priority
        send_item(ppnq_pkg::FUNC_TICK, '0, '0, ppnq_pkg::PRI_STANDARD, '0, 16'd0);
        send_item(ppnq_pkg::FUNC_DISMISS, '0, '0, ppnq_pkg::PRI_STANDARD, 8'hFF, '0);
        send_item(ppnq_pkg::FUNC_RECEIVE, 32'hFFFF_FFFF, 32'h0, PRI_INVALID_A, '0, '0);
        send_item(ppnq_pkg::FUNC_RECEIVE, 32'h0, 32'hFFFF_FFFF, PRI_INVALID_B, 8'hFF,
                  16'hFFFF);
        send_item(ppnq_pkg::FUNC_RECEIVE, 32'h0, 32'h0, ppnq_pkg::PRI_STANDARD, '0, '0);
        send_item(ppnq_pkg::FUNC_RECEIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ppnq_pkg::PRI_HIGH,
                  '0, '0);
        // one short of the reset gap, then exactly on it, then dismisses with a wrong and the right tag
        send_item(ppnq_pkg::FUNC_TICK, '0, '0, ppnq_pkg::PRI_STANDARD, '0,
                  ppnq_pkg::GAP_RESET - 16'd1);
        send_item(ppnq_pkg::FUNC_TICK, '0, '0, ppnq_pkg::PRI_STANDARD, '0, 16'd1);
        send_item(ppnq_pkg::FUNC_DISMISS, '0, '0, ppnq_pkg::PRI_STANDARD,
                  sb.head_tag() ^ 8'h80, '0);
        send_item(ppnq_pkg::FUNC_DISMISS, '0, '0, ppnq_pkg::PRI_STANDARD, sb.head_tag(), '0);
        // pop followed by a presentation, then saturate the timer
        send_item(ppnq_pkg::FUNC_TICK, '0, '0, ppnq_pkg::PRI_STANDARD, '0,
                  ppnq_pkg::ELAPSED_MAX);
        send_item(ppnq_pkg::FUNC_TICK, '0, '0, ppnq_pkg::PRI_STANDARD, '0,
                  ppnq_pkg::ELAPSED_MAX);
        send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PRI_INVALID_B, 8'hFF, 16'hFFFF);
        // fill the ring from both ends, last one bounces off a full queue
        for (int i = 0; i < RING_DEPTH; i++)
            send_item(ppnq_pkg::FUNC_RECEIVE, $urandom, $urandom,
                      i[0] ? ppnq_pkg::PRI_HIGH : ppnq_pkg::PRI_STANDARD,
                      8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    // mostly well-formed notice lifecycles with random content, some noise
    task automatic send_random_item();
        int          pick;
        int          roll;
        int          recv_w;
        int          span;
        logic [1:0]  func;
        logic [1:0]  pri;
        logic [7:0]  dtag;
        logic [15:0] delta;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        recv_w = (sb.count >= 12) ? 20 : 45;
        pri = ppnq_pkg::PRI_STANDARD;
        dtag = 8'($urandom_range(0, 255));
        delta = 16'($urandom_range(0, 65535));
        if (pick < 4) begin
            func = FUNC_UNUSED;
            pri = 2'($urandom_range(0, 3));
        end else if (pick < 4 + recv_w) begin
            func = ppnq_pkg::FUNC_RECEIVE;
            if (roll < 50)
                pri = ppnq_pkg::PRI_STANDARD;
            else if (roll < 85)
                pri = ppnq_pkg::PRI_HIGH;
            else
                pri = roll[0] ? PRI_INVALID_A : PRI_INVALID_B;
        end else if (pick < 24 + recv_w) begin
            func = ppnq_pkg::FUNC_DISMISS;
            if (sb.count > 0 && roll < 80)
                dtag = sb.head_tag();
        end else begin
            func = ppnq_pkg::FUNC_TICK;
            span = sb.gap + sb.gap / 2 + 20;
            if (span > ppnq_pkg::ELAPSED_MAX)
                span = ppnq_pkg::ELAPSED_MAX;
            if (roll < 15)
                delta = 16'd0;
            else if (roll < 30)
                delta = ppnq_pkg::ELAPSED_MAX;
            else if (roll >= 50)
                delta = 16'($urandom_range(0, span));
        end
        send_item(func, $urandom, $urandom, pri, dtag, delta);
        random_items = random_items + 1;
    endtask

    function automatic logic [15:0] pick_gap(input int ph);
        case (ph % 6)
            0: return 16'd0;
            1: return ppnq_pkg::ELAPSED_MAX;
            2: return 16'd1;
            3: return ppnq_pkg::GAP_RESET;
            4: return 16'($urandom_range(0, 4000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        run_directed();
        while (random_items < RANDOM_ITEMS) begin
            drain();
            write_gap(pick_gap(phase));
            burst_left = 0;
            for (int k = 0; k < PHASE_ITEMS && random_items < RANDOM_ITEMS; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    // every third phase runs back to back with no gaps
                    if (phase % 3 != 2)
                        idle_for($urandom_range(0, 5));
                end
                send_random_item();
                burst_left = burst_left - 1;
            end
            phase = phase + 1;
        end
        drain();
        if (sb.errors == 0)
            $display("paced_priority_notice_queue regression: pass");
        else
            $display("paced_priority_notice_queue regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
